// ----- src/xbf_pkg.sv -----
// Shared types, constants and the CRC-16 byte step of the block framer.
`timescale 1ns / 1ps

package xbf_pkg;

  // Default number of data bytes in one block.
  localparam int unsigned XBF_CHUNK_BYTES_DEF = 128;

  localparam logic [7:0]  XBF_SOH_CODE = 8'h01;
  localparam logic [7:0]  XBF_PAD_CODE = 8'h1A;
  localparam logic [15:0] XBF_CRC_POLY = 16'h1021;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PAD   = 3'b010,
    ST_CHECK = 3'b100
  } xbf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // take the input byte and load its word
    logic pad_absorb;  // fold one pad byte into the pending pad word
    logic pad_emit;    // fold the final pad byte of a word and load the word
    logic check_emit;  // load the check word and clear the block state
  } xbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_load;        // output register is free this cycle
    logic fill_next_full;  // the next byte placed completes the block
    logic pad_last;        // the next pad byte completes a pad word
  } xbf_status_t;

  // One byte of CRC-16/XMODEM, MSB first, eight shift steps.
  function automatic logic [15:0] xbf_crc_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ XBF_CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- src/xbf_ctrl.sv -----
// Controller state machine of the block framer.
`timescale 1ns / 1ps

module xbf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                end_of_file_i,
  output logic                in_stall_o,
  input  xbf_pkg::xbf_status_t status_i,
  output xbf_pkg::xbf_cmd_t    cmd_o
);
  import xbf_pkg::*;

  xbf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = !status_i.can_load;
        if (status_i.can_load && in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.fill_next_full) begin
            state_d = ST_CHECK;
          end else if (end_of_file_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (status_i.pad_last) begin
          if (status_i.can_load) begin
            cmd_o.pad_emit = 1'b1;
            if (status_i.fill_next_full) begin
              state_d = ST_CHECK;
            end
          end
        end else begin
          cmd_o.pad_absorb = 1'b1;
        end
      end
      ST_CHECK: begin
        if (status_i.can_load) begin
          cmd_o.check_emit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/xbf_datapath.sv -----
// Datapath of the block framer: block state, checks and the output register.
`timescale 1ns / 1ps

module xbf_datapath #(
  parameter int unsigned CHUNK_BYTES = xbf_pkg::XBF_CHUNK_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_file_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [31:0]          frame_bytes_o,
  output logic [2:0]           byte_count_o,
  output logic                 end_of_block_o,
  output logic                 last_of_run_o,
  input  xbf_pkg::xbf_cmd_t    cmd_i,
  output xbf_pkg::xbf_status_t status_o
);
  import xbf_pkg::*;

  localparam int unsigned FILL_W = $clog2(CHUNK_BYTES + 1);
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(CHUNK_BYTES - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CHUNK_BYTES);

  logic              crc_mode_q;
  logic [7:0]        blk_q, blk_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        sum_q, sum_d;
  logic [15:0]       crc_q, crc_d;
  logic [1:0]        pad_k_q, pad_k_d;

  logic              ovalid_q, ovalid_d;
  logic [31:0]       oword_q, oword_d;
  logic [2:0]        ocount_q, ocount_d;
  logic              oeob_q, oeob_d;
  logic              olast_q, olast_d;

  logic              load;
  logic              absorb;
  logic [7:0]        absorb_byte;
  logic [7:0]        num;
  logic [31:0]       pad_word;

  assign status_o.can_load       = !ovalid_q || !out_stall_i;
  assign status_o.fill_next_full = (fill_q >= LAST_FILL);
  assign status_o.pad_last       = (pad_k_q == 2'd3) || status_o.fill_next_full;

  assign load        = cmd_i.accept || cmd_i.pad_emit || cmd_i.check_emit;
  assign absorb      = cmd_i.accept || cmd_i.pad_absorb || cmd_i.pad_emit;
  assign absorb_byte = cmd_i.accept ? data_byte_i : XBF_PAD_CODE;
  assign num         = blk_q + 8'd1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pad_word[8*i +: 8] = (2'(i) <= pad_k_q) ? XBF_PAD_CODE : 8'h00;
    end
  end

  always_comb begin
    blk_d    = blk_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    crc_d    = crc_q;
    pad_k_d  = pad_k_q;
    oword_d  = oword_q;
    ocount_d = ocount_q;
    oeob_d   = oeob_q;
    olast_d  = olast_q;

    if (absorb) begin
      fill_d = fill_q + FILL_W'(1);
      sum_d  = sum_q + absorb_byte;
      crc_d  = xbf_crc_byte(crc_q, absorb_byte);
    end

    if (cmd_i.accept) begin
      if (fill_q == '0) begin
        oword_d  = {data_byte_i, ~num, num, XBF_SOH_CODE};
        ocount_d = 3'd4;
        blk_d    = end_of_file_i ? 8'd0 : num;
      end else begin
        oword_d  = {24'd0, data_byte_i};
        ocount_d = 3'd1;
        if (end_of_file_i) begin
          blk_d = 8'd0;
        end
      end
      oeob_d  = 1'b0;
      olast_d = !end_of_file_i && !status_o.fill_next_full;
      pad_k_d = 2'd0;
    end

    if (cmd_i.pad_absorb) begin
      pad_k_d = pad_k_q + 2'd1;
    end

    if (cmd_i.pad_emit) begin
      oword_d  = pad_word;
      ocount_d = {1'b0, pad_k_q} + 3'd1;
      oeob_d   = 1'b0;
      olast_d  = 1'b0;
      pad_k_d  = 2'd0;
    end

    if (cmd_i.check_emit) begin
      if (crc_mode_q) begin
        oword_d  = {16'd0, crc_q[7:0], crc_q[15:8]};
        ocount_d = 3'd2;
      end else begin
        oword_d  = {24'd0, sum_q};
        ocount_d = 3'd1;
      end
      oeob_d  = 1'b1;
      olast_d = 1'b1;
      fill_d  = '0;
      sum_d   = 8'd0;
      crc_d   = 16'd0;
    end
  end

  assign ovalid_d = load || (ovalid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q <= 1'b1;
      blk_q      <= 8'd0;
      fill_q     <= '0;
      sum_q      <= 8'd0;
      crc_q      <= 16'd0;
      pad_k_q    <= 2'd0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        crc_mode_q <= cfg_wdata_i;
      end
      blk_q    <= blk_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      crc_q    <= crc_d;
      pad_k_q  <= pad_k_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oword_q  <= oword_d;
    ocount_q <= ocount_d;
    oeob_q   <= oeob_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o    = ovalid_q;
  assign frame_bytes_o  = oword_q;
  assign byte_count_o   = ocount_q;
  assign end_of_block_o = oeob_q;
  assign last_of_run_o  = olast_q;

  // The fill count never runs past a full block.
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_FILL)
    else $error("fill count beyond block length");

  // At most one command in any cycle.
  a_cmd_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.accept, cmd_i.pad_absorb, cmd_i.pad_emit, cmd_i.check_emit}))
    else $error("conflicting datapath commands");

  // Closing a block leaves the block state clear for the next one.
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check_emit |=> (fill_q == '0) && (sum_q == 8'd0) && (crc_q == 16'd0))
    else $error("block state not cleared after check word");

  // A word is only loaded while the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |-> !load)
    else $error("output register overwritten while stalled");

  // A check word always ends the run of its input transaction.
  a_eob_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oeob_q) |-> olast_q)
    else $error("check word not marked last of run");

endmodule

// ----- src/xmodem_block_framer.sv -----
// Top level of the XMODEM block framer with checksum or CRC-16 check field.
`timescale 1ns / 1ps

// The framer takes file bytes, one per input transaction, each with an
// end-of-file flag, and sends XMODEM blocks out as words of one to four
// bytes, first transmitted byte in bits 7:0 and unused upper bytes zero.
// A block is SOH, the block number (1 for the first block of a file,
// wrapping after 255), its complement and CHUNK_BYTES data bytes; a file
// that ends short of a full block is padded with 0x1A. The block closes
// with a one-byte arithmetic sum (crc_mode 0) or a CRC-16/XMODEM sent high
// byte first (crc_mode 1, the reset value); the check type is the one set
// when the block closes. The first byte of a block leaves as a four-byte
// word together with the header, every other data byte as a one-byte word.
// last_of_run_o marks the final word caused by an input transaction, and
// end_of_block_o the check word. An ordinary byte loads one word into the
// output register, and a byte that completes a block is followed by the
// check word. Pad bytes pass the one-byte CRC step one per cycle, the last
// of each pad word waiting for a free output register, and the byte that
// ends a file holds the input until its pad words and the check word are
// loaded. A single output register parts the two sides, so a new byte is
// taken in the same cycle that the previous word leaves. crc_mode is to be
// written only while the block is idle; the block does not enforce this.

module xmodem_block_framer #(
  parameter int unsigned CHUNK_BYTES = xbf_pkg::XBF_CHUNK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] frame_bytes_o,
  output logic [2:0]  byte_count_o,
  output logic        end_of_block_o,
  output logic        last_of_run_o
);
  import xbf_pkg::*;

  xbf_cmd_t    cmd;
  xbf_status_t status;

  // The controller sequences header, data, pad and check words.
  xbf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .end_of_file_i(end_of_file_i),
    .in_stall_o   (in_stall_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // The datapath keeps the block number, fill count, running sum and CRC,
  // and the output register that holds one word until it is taken.
  xbf_datapath #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .frame_bytes_o (frame_bytes_o),
    .byte_count_o  (byte_count_o),
    .end_of_block_o(end_of_block_o),
    .last_of_run_o (last_of_run_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
